### hdl/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// Shared types, codes and defaults for the HTTP request line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlc_pkg;

	// Default sizes
	localparam int PATH_KEEP_DEF    = 30;
	localparam int VERSION_KEEP_DEF = 10;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [7:0] MAX_HDR_RESET = 8'd20;

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_S     = 8'h53;

	// Result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_MISSING     = 3'd2;
	localparam logic [2:0] ST_BAD_VERB    = 3'd3;
	localparam logic [2:0] ST_BAD_PATH    = 3'd4;
	localparam logic [2:0] ST_BAD_VERSION = 3'd5;

	// Classified input beat, handed from front to back
	typedef struct packed {
		logic eoi;
		logic is_zero;
		logic is_lf;
		logic is_cr;
		logic is_space;
		logic is_slash;
		logic path_ok;
		logic is_g;
		logic is_e;
		logic is_t;
		logic is_p;
		logic is_o;
		logic is_s;
	} cls_t;

	// One result item
	typedef struct packed {
		logic [3:0] version_length;
		logic [4:0] path_length;
		logic       verb_is_post;
		logic [2:0] status;
	} res_t;

endpackage

`default_nettype wire

### hdl/hrlc_front.sv
// ----------------------------------------------------------------------------
// hrlc_front
// Accepts input beats and classifies each byte into a set of flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_front (
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [7:0]      s_axis_tdata,   // [7:0] byte_value
	input  wire logic            s_axis_tuser,   // [0] end_of_input
	output logic                 push,
	output hrlc_pkg::cls_t       push_cls,
	input  wire logic            q_full
);
	import hrlc_pkg::*;

	logic [7:0] b;
	logic       letter;
	logic       digit;

	assign b      = s_axis_tdata;
	assign letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	assign digit  = (b >= 8'h30) && (b <= 8'h39);

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		push_cls          = '0;
		push_cls.eoi      = s_axis_tuser;
		push_cls.is_zero  = (b == CH_NUL);
		push_cls.is_lf    = (b == CH_LF);
		push_cls.is_cr    = (b == CH_CR);
		push_cls.is_space = (b == CH_SPACE);
		push_cls.is_slash = (b == CH_SLASH);
		push_cls.path_ok  = letter || digit || (b == CH_SLASH) || (b == CH_DOT)
			|| (b == CH_UNDER) || (b == CH_DASH);
		push_cls.is_g     = (b == CH_G);
		push_cls.is_e     = (b == CH_E);
		push_cls.is_t     = (b == CH_T);
		push_cls.is_p     = (b == CH_P);
		push_cls.is_o     = (b == CH_O);
		push_cls.is_s     = (b == CH_S);
	end

endmodule

`default_nettype wire

### hdl/hrlc_queue.sv
// ----------------------------------------------------------------------------
// hrlc_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_queue #(
	parameter int DEPTH = hrlc_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hrlc_pkg::cls_t  push_cls,
	output logic                 full,
	input  wire logic            pop,
	output logic                 q_valid,
	output hrlc_pkg::cls_t       q_cls
);
	import hrlc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/hrlc_back.sv
// ----------------------------------------------------------------------------
// hrlc_back
// Request state machine: tracks tokens and headers, emits one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_back #(
	parameter int PATH_KEEP    = hrlc_pkg::PATH_KEEP_DEF,
	parameter int VERSION_KEEP = hrlc_pkg::VERSION_KEEP_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [7:0]      max_header_lines,
	input  wire logic            q_valid,
	input  wire hrlc_pkg::cls_t  q_cls,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  wire logic            m_axis_tready,
	output logic [15:0]          m_axis_tdata
);
	import hrlc_pkg::*;

	localparam int PCW = $clog2(PATH_KEEP + 1);
	localparam int VCW = $clog2(VERSION_KEEP + 1);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_LINE    = 3'd1;
	localparam logic [2:0] PH_DEAD    = 3'd2;
	localparam logic [2:0] PH_HEADERS = 3'd3;
	localparam logic [2:0] PH_LAST    = 3'd4;

	logic [2:0]     phase_q,   n_phase;
	logic [1:0]     tidx_q,    n_tidx;
	logic           in_tok_q,  n_in_tok;
	logic [2:0]     vcnt_q,    n_vcnt;
	logic [1:0]     vflag_q,   n_vflag;
	logic [PCW-1:0] pcnt_q,    n_pcnt;
	logic           pvalid_q,  n_pvalid;
	logic [VCW-1:0] vercnt_q,  n_vercnt;
	logic           vernl_q,   n_vernl;
	logic [7:0]     hseen_q,   n_hseen;
	logic           hstart_q,  n_hstart;

	logic           emit;
	logic [2:0]     st;
	logic           ev_post;
	logic           ev_get;
	logic [2:0]     ev_st;
	logic           skip;
	logic           get_hit;
	logic           post_hit;
	logic           out_valid_q;
	res_t           out_q;
	res_t           res;

	assign pop           = q_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	always_comb begin
		n_phase  = phase_q;
		n_tidx   = tidx_q;
		n_in_tok = in_tok_q;
		n_vcnt   = vcnt_q;
		n_vflag  = vflag_q;
		n_pcnt   = pcnt_q;
		n_pvalid = pvalid_q;
		n_vercnt = vercnt_q;
		n_vernl  = vernl_q;
		n_hseen  = hseen_q;
		n_hstart = hstart_q;
		emit     = 1'b0;
		st       = ST_OK;
		skip     = 1'b0;
		get_hit  = 1'b0;
		post_hit = 1'b0;
		ev_get   = 1'b0;
		ev_post  = 1'b0;
		ev_st    = ST_OK;

		if (!q_cls.eoi) begin
			if (n_phase == PH_IDLE) begin
				n_phase = PH_LINE;
			end
			if ((n_phase == PH_LINE) || (n_phase == PH_DEAD)) begin
				if (n_phase == PH_LINE) begin
					if (q_cls.is_zero) begin
						n_phase = PH_DEAD;
					end else if (q_cls.is_space) begin
						n_in_tok = 1'b0;
					end else begin
						if (!n_in_tok) begin
							n_in_tok = 1'b1;
							if (n_tidx == 2'd3) begin
								n_phase = PH_DEAD;
								skip    = 1'b1;
							end else begin
								n_tidx = n_tidx + 2'd1;
							end
						end
						if (!skip) begin
							if (n_tidx == 2'd1) begin
								case (n_vcnt)
									3'd0: begin
										get_hit  = q_cls.is_g;
										post_hit = q_cls.is_p;
									end
									3'd1: begin
										get_hit  = q_cls.is_e;
										post_hit = q_cls.is_o;
									end
									3'd2: begin
										get_hit  = q_cls.is_t;
										post_hit = q_cls.is_s;
									end
									3'd3: begin
										post_hit = q_cls.is_t;
									end
									default: begin
										get_hit  = 1'b0;
										post_hit = 1'b0;
									end
								endcase
								if (!get_hit) n_vflag[0] = 1'b0;
								if (!post_hit) n_vflag[1] = 1'b0;
								if (n_vcnt != 3'd7) n_vcnt = n_vcnt + 3'd1;
							end else if (n_tidx == 2'd2) begin
								if (n_pcnt < PCW'(PATH_KEEP)) begin
									if (n_pcnt == '0) begin
										if (!q_cls.is_slash) n_pvalid = 1'b0;
									end else if (!q_cls.path_ok) begin
										n_pvalid = 1'b0;
									end
									n_pcnt = n_pcnt + 1'b1;
								end
							end else begin
								if ((n_vercnt == '0) && q_cls.is_lf) n_vernl = 1'b1;
								if (n_vercnt < VCW'(VERSION_KEEP)) begin
									n_vercnt = n_vercnt + 1'b1;
								end
							end
						end
					end
				end
				if (q_cls.is_lf) begin
					emit = 1'b1;
				end
			end else if (n_phase == PH_HEADERS) begin
				if (n_hstart) begin
					if (q_cls.is_lf) begin
						emit = 1'b1;
					end else if (q_cls.is_cr) begin
						n_phase = PH_LAST;
					end else begin
						n_hstart = 1'b0;
					end
				end else if (q_cls.is_lf) begin
					if (n_hseen != 8'd255) n_hseen = n_hseen + 8'd1;
					if (n_hseen >= max_header_lines) begin
						emit = 1'b1;
					end else begin
						n_hstart = 1'b1;
					end
				end
			end else begin
				if (q_cls.is_lf) emit = 1'b1;
			end
		end else begin
			emit = 1'b1;
		end

		// Evaluate the line on the updated token state
		ev_get  = n_vflag[0] && (n_vcnt == 3'd3);
		ev_post = n_vflag[1] && (n_vcnt == 3'd4);
		if (n_tidx != 2'd3) ev_st = ST_MISSING;
		else if (!ev_get && !ev_post) ev_st = ST_BAD_VERB;
		else if (!n_pvalid) ev_st = ST_BAD_PATH;
		else if (n_vernl) ev_st = ST_BAD_VERSION;
		else ev_st = ST_OK;

		if (q_cls.eoi) begin
			if (phase_q == PH_IDLE) st = ST_EMPTY;
			else if ((phase_q == PH_LINE) || (phase_q == PH_DEAD)) st = ev_st;
			else st = ST_OK;
		end else if ((phase_q == PH_IDLE) || (phase_q == PH_LINE)
			|| (phase_q == PH_DEAD)) begin
			// Line ends: report at once on an error or a zero header limit, else move on to headers
			if (emit) begin
				st = ev_st;
				if ((ev_st == ST_OK) && (max_header_lines != 8'd0)) begin
					emit     = 1'b0;
					n_phase  = PH_HEADERS;
					n_hseen  = 8'd0;
					n_hstart = 1'b1;
				end
			end
		end else begin
			st = ST_OK;
		end

		res                = '0;
		res.status         = st;
		res.verb_is_post   = (st == ST_OK) && ev_post;
		res.path_length    = 5'(n_pcnt);
		res.version_length = 4'(n_vercnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tidx_q      <= '0;
			in_tok_q    <= 1'b0;
			vcnt_q      <= '0;
			vflag_q     <= 2'b11;
			pcnt_q      <= '0;
			pvalid_q    <= 1'b1;
			vercnt_q    <= '0;
			vernl_q     <= 1'b0;
			hseen_q     <= '0;
			hstart_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (emit) begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_IDLE;
					tidx_q      <= '0;
					in_tok_q    <= 1'b0;
					vcnt_q      <= '0;
					vflag_q     <= 2'b11;
					pcnt_q      <= '0;
					pvalid_q    <= 1'b1;
					vercnt_q    <= '0;
					vernl_q     <= 1'b0;
					hseen_q     <= '0;
					hstart_q    <= 1'b1;
				end else begin
					phase_q     <= n_phase;
					tidx_q      <= n_tidx;
					in_tok_q    <= n_in_tok;
					vcnt_q      <= n_vcnt;
					vflag_q     <= n_vflag;
					pcnt_q      <= n_pcnt;
					pvalid_q    <= n_pvalid;
					vercnt_q    <= n_vercnt;
					vernl_q     <= n_vernl;
					hseen_q     <= n_hseen;
					hstart_q    <= n_hstart;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

### hdl/http_request_line_checker_top.sv
// ----------------------------------------------------------------------------
// http_request_line_checker_top
// Checks the request line of an HTTP request stream, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock unless stalled: a front stage classifies each
// byte (space, CR, LF, NUL, verb letters, legal path characters), a
// two-entry queue decouples it from the back stage, and the back stage runs
// the request state machine, one byte per cycle while its output is free,
// into a registered result beat (queue write, then state machine plus
// output register). The input only stalls while the output beat is held by
// m_axis_tready low and the queue has filled. A result is given on the LF
// that closes the first line if it is erroneous or max_header_lines is
// zero, on the LF that ends the header block (a line starting with CR or
// LF, or max_header_lines lines), or on an end_of_input beat.
// Write max_header_lines only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_line_checker_top #(
	parameter int PATH_KEEP    = hrlc_pkg::PATH_KEEP_DEF,
	parameter int VERSION_KEEP = hrlc_pkg::VERSION_KEEP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write: max_header_lines
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// request byte stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  wire logic        s_axis_tuser,   // [0] end_of_input
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata    // [2:0] status, [3] verb_is_post,
	                                         // [8:4] path_length,
	                                         // [12:9] version_length
);
	import hrlc_pkg::*;

	logic       cfg_take;
	logic [7:0] max_hdr_lines_q;
	logic       push;
	cls_t       push_cls;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	cls_t       q_cls;

	// Always take configuration beats
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_lines_q <= MAX_HDR_RESET;
		end else if (cfg_take) begin
			max_hdr_lines_q <= cfg_data;
		end
	end

	// Front: accept and classify each byte
	hrlc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_cls      (push_cls),
		.q_full        (q_full)
	);

	// Queue: hold classified beats while the back stage is stalled
	hrlc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cls    (q_cls)
	);

	// Back: advance the request state machine and drive the result beat
	hrlc_back #(
		.PATH_KEEP    (PATH_KEEP),
		.VERSION_KEEP (VERSION_KEEP)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_header_lines (max_hdr_lines_q),
		.q_valid          (q_valid),
		.q_cls            (q_cls),
		.pop              (pop),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata)
	);

endmodule

`default_nettype wire

### verif/hrlc_result_check.sv
// ----------------------------------------------------------------------------
// hrlc_result_check
// Watches the byte, result and configuration channels of the request line
// checker, works out the verdict each accepted byte leads to and compares
// every result beat, field by field, with the oldest verdict still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_result_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  wire logic        s_axis_tuser,   // [0] end_of_input
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,   // [2:0] status, [3] verb_is_post,
	                                         // [8:4] path_length,
	                                         // [12:9] version_length
	output int               results_owed,
	output int               mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	import hrlc_pkg::*;

	localparam int PATH_KEEP    = PATH_KEEP_DEF;
	localparam int VERSION_KEEP = VERSION_KEEP_DEF;

	typedef enum logic [2:0] {
		REQ_IDLE,       // nothing received since the last verdict
		REQ_LINE,       // inside the request line
		REQ_LINE_SKIP,  // rest of the request line ignored
		REQ_HEADERS,    // skipping header lines
		REQ_AFTER_CR    // a header line opened with CR
	} req_phase_e;

	req_phase_e  req_phase;
	logic [1:0]  tok_num;
	logic        tok_open;
	logic [2:0]  verb_len;
	logic        can_get;
	logic        can_post;
	logic [4:0]  path_len;
	logic        path_good;
	logic [3:0]  ver_len;
	logic        ver_lf_first;
	logic [7:0]  hdr_lines;
	logic        at_line_start;
	logic [7:0]  hdr_limit;

	res_t        verdicts_due[$];

	function automatic void start_over();
		req_phase     = REQ_IDLE;
		tok_num       = '0;
		tok_open      = 1'b0;
		verb_len      = '0;
		can_get       = 1'b1;
		can_post      = 1'b1;
		path_len      = '0;
		path_good     = 1'b1;
		ver_len       = '0;
		ver_lf_first  = 1'b0;
		hdr_lines     = '0;
		at_line_start = 1'b1;
	endfunction

	function automatic logic is_post();
		return can_post && verb_len == 3'd4;
	endfunction

	function automatic logic [2:0] line_status();
		if (tok_num < 2'd3)
			return ST_MISSING;
		if (!(can_get && verb_len == 3'd3) && !is_post())
			return ST_BAD_VERB;
		if (!path_good)
			return ST_BAD_PATH;
		if (ver_lf_first)
			return ST_BAD_VERSION;
		return ST_OK;
	endfunction

	function automatic void post_verdict(input logic [2:0] st);
		res_t r;
		r.status         = st;
		r.verb_is_post   = (st == ST_OK) && is_post();
		r.path_length    = path_len;
		r.version_length = ver_len;
		verdicts_due.push_back(r);
		start_over();
	endfunction

	function automatic logic path_char_legal(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
		       (b >= "0" && b <= "9") || b == CH_SLASH || b == CH_DOT ||
		       b == CH_UNDER || b == CH_DASH;
	endfunction

	// One byte of the request line that is not a NUL
	function automatic void take_token_byte(input logic [7:0] b);
		logic [7:0] get_ch;
		logic [7:0] post_ch;
		if (b == CH_SPACE) begin
			tok_open = 1'b0;
			return;
		end
		if (!tok_open) begin
			tok_open = 1'b1;
			if (tok_num == 2'd3) begin
				req_phase = REQ_LINE_SKIP;
				return;
			end
			tok_num = tok_num + 2'd1;
		end
		case (tok_num)
			2'd1: begin
				get_ch  = (verb_len == 3'd0) ? CH_G : (verb_len == 3'd1) ? CH_E : CH_T;
				post_ch = (verb_len == 3'd0) ? CH_P : (verb_len == 3'd1) ? CH_O :
				          (verb_len == 3'd2) ? CH_S : CH_T;
				if (verb_len >= 3'd3 || b != get_ch)
					can_get = 1'b0;
				if (verb_len >= 3'd4 || b != post_ch)
					can_post = 1'b0;
				if (verb_len < 3'd7)
					verb_len = verb_len + 3'd1;
			end
			2'd2: begin
				if (path_len < PATH_KEEP) begin
					if (path_len == 5'd0) begin
						if (b != CH_SLASH)
							path_good = 1'b0;
					end else if (!path_char_legal(b)) begin
						path_good = 1'b0;
					end
					path_len = path_len + 5'd1;
				end
			end
			default: begin
				if (ver_len == 4'd0 && b == CH_LF)
					ver_lf_first = 1'b1;
				if (ver_len < VERSION_KEEP)
					ver_len = ver_len + 4'd1;
			end
		endcase
	endfunction

	function automatic void take_beat(input logic [7:0] b, input logic eoi);
		if (eoi) begin
			case (req_phase)
				REQ_IDLE:                post_verdict(ST_EMPTY);
				REQ_LINE, REQ_LINE_SKIP: post_verdict(line_status());
				default:                 post_verdict(ST_OK);
			endcase
			return;
		end
		if (req_phase == REQ_IDLE)
			req_phase = REQ_LINE;
		case (req_phase)
			REQ_LINE, REQ_LINE_SKIP: begin
				// a NUL ends the useful part of the line
				if (req_phase == REQ_LINE) begin
					if (b == CH_NUL)
						req_phase = REQ_LINE_SKIP;
					else
						take_token_byte(b);
				end
				if (b == CH_LF) begin
					if (line_status() != ST_OK || hdr_limit == 8'd0) begin
						post_verdict(line_status());
					end else begin
						req_phase     = REQ_HEADERS;
						hdr_lines     = '0;
						at_line_start = 1'b1;
					end
				end
			end
			REQ_HEADERS: begin
				if (at_line_start) begin
					if (b == CH_LF)
						post_verdict(ST_OK);
					else if (b == CH_CR)
						req_phase = REQ_AFTER_CR;
					else
						at_line_start = 1'b0;
				end else if (b == CH_LF) begin
					if (hdr_lines != 8'hFF)
						hdr_lines = hdr_lines + 8'd1;
					if (hdr_lines >= hdr_limit)
						post_verdict(ST_OK);
					else
						at_line_start = 1'b1;
				end
			end
			default: begin
				if (b == CH_LF)
					post_verdict(ST_OK);
			end
		endcase
	endfunction

	always @(posedge clk) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			start_over();
			hdr_limit = MAX_HDR_RESET;
			verdicts_due.delete();
			mismatches = 0;
		end else begin
			// results first: a verdict is always owed before its result beat shows
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(res_t)-1:0];
				if (verdicts_due.size() == 0) begin
					$error("unexpected result beat: status %0d", got.status);
					mismatches++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.verb_is_post != want.verb_is_post) begin
						$error("verb_is_post: expected %0d, got %0d",
						       want.verb_is_post, got.verb_is_post);
						mismatches++;
					end
					if (got.path_length != want.path_length) begin
						$error("path_length: expected %0d, got %0d",
						       want.path_length, got.path_length);
						mismatches++;
					end
					if (got.version_length != want.version_length) begin
						$error("version_length: expected %0d, got %0d",
						       want.version_length, got.version_length);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				hdr_limit = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				take_beat(s_axis_tdata, s_axis_tuser);
		end
		results_owed <= verdicts_due.size();
	end

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the HTTP request line checker: directed requests for each
// corner of the line rules, then phases of random requests and noise under
// several header limits and flow-control patterns, checked beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hrlc_pkg::*;

	// Cycles with no beat on any channel before the run is declared hung.
	// Must cover the long sink hold-off below with ample margin.
	localparam int QUIET_LIMIT  = 2000;
	// Sink hold-off during the pressure phase, long enough to fill the
	// two-entry queue and the output register so the byte input stalls
	localparam int LONG_HOLD    = 300;
	// Settling wait after the last owed result, before touching config
	localparam int PIPE_DRAIN   = 4;
	localparam int END_SETTLE   = 20;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_BEATS  = 100;
	localparam int PRESSURE_IDX = 4;

	typedef enum logic [1:0] {
		FLOW_FREE,        // no gaps either side
		FLOW_SRC_GAPS,    // sender idles in most cycles
		FLOW_SINK_STALLS, // receiver stalls in most cycles
		FLOW_BOTH         // moderate gaps on both sides
	} flow_e;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;   // [7:0] byte_value
	logic        s_axis_tuser  = 1'b0; // [0] end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [2:0] status, [3] verb_is_post,
	                                   // [8:4] path_length, [12:9] version_length

	int          results_owed;
	int          mismatches;

	flow_e       flow          = FLOW_FREE;
	logic        pressure_on   = 1'b0;
	int          sink_hold     = 0;
	int          quiet         = 0;
	int          beats_sent    = 0;

	logic [8:0]  pending_beats[$];     // {end_of_input, byte}
	string       path_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/._-";
	string       verb_set = "GETPOS";

	http_request_line_checker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hrlc_result_check check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.results_owed  (results_owed),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result sink. During the pressure phase hold tready low for a long
	// stretch first, counted here, so the block backs up into its input;
	// otherwise stall at the rate the current flow pattern asks for.
	always @(posedge clk) begin
		if (pressure_on && sink_hold < LONG_HOLD) begin
			m_axis_tready <= 1'b0;
			sink_hold     <= sink_hold + 1;
		end else if (flow == FLOW_SINK_STALLS) begin
			m_axis_tready <= $urandom_range(99) >= 86;
		end else if (flow == FLOW_BOTH) begin
			m_axis_tready <= $urandom_range(99) >= 30;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog: count cycles in which no beat moves on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		pending_beats.push_back({1'b0, b});
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_beats.push_back({1'b0, s[i]});
	endtask

	task automatic add_line(input string s);
		add_text(s);
		add_byte(CH_LF);
	endtask

	// The byte lane carries random junk on an end-of-input beat
	task automatic add_eoi();
		pending_beats.push_back({1'b1, 8'($urandom_range(255))});
	endtask

	// Offer one beat, idling first as the flow pattern asks; hold it until taken
	task automatic offer(input logic [8:0] beat);
		int gap_pct;
		gap_pct = (flow == FLOW_SRC_GAPS) ? 86 : (flow == FLOW_BOTH) ? 30 : 0;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat[7:0];
		s_axis_tuser  <= beat[8];
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic send_all();
		while (pending_beats.size() != 0)
			offer(pending_beats.pop_front());
	endtask

	// Drop valid, wait for every owed result, let the pipeline drain, then
	// write the header limit while nothing is in flight
	task automatic drain_and_set_limit(input logic [7:0] limit);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] path_byte();
		int r;
		r = $urandom_range(99);
		if (r < 94)
			return path_set[$urandom_range(path_set.len() - 1)];
		if (r < 98)
			return 8'($urandom_range(33, 255));
		return CH_NUL;
	endfunction

	// Build one random request: mostly well-formed lines with random
	// content and header blocks, some broken ones, some raw noise
	task automatic make_request();
		int kind;
		int r;
		int first;
		int cut;
		first = pending_beats.size();
		kind  = $urandom_range(99);
		if (kind >= 90) begin
			// raw noise across the whole byte range
			repeat ($urandom_range(1, 24)) add_byte(8'($urandom_range(255)));
			if ($urandom_range(1))
				add_byte(CH_LF);
			if ($urandom_range(1))
				add_eoi();
			return;
		end
		if (kind >= 86) begin
			add_eoi();
			return;
		end
		repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) add_byte(CH_SPACE);
		// verb
		r = $urandom_range(99);
		if (r < 40)
			add_text("GET");
		else if (r < 80)
			add_text("POST");
		else
			repeat ($urandom_range(1, 5))
				add_byte((r < 95) ? verb_set[$urandom_range(verb_set.len() - 1)] :
				         8'($urandom_range(33, 126)));
		// path, sometimes absent
		if ($urandom_range(99) < 8) begin
			add_byte(CH_LF);
		end else begin
			repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
			add_byte(($urandom_range(99) < 92) ? CH_SLASH : path_byte());
			repeat (($urandom_range(99) < 85) ? $urandom_range(0, 10) : $urandom_range(25, 36))
				add_byte(path_byte());
			// version, sometimes absent or opening with LF
			r = $urandom_range(99);
			if (r >= 10)
				repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
			if (r >= 16) begin
				if ($urandom_range(99) < 60)
					add_text($urandom_range(1) ? "HTTP/1.1" : "HTTP/1.0");
				else
					repeat ($urandom_range(1, 14)) add_byte(8'($urandom_range(33, 126)));
				if ($urandom_range(99) < 8) begin
					add_byte(CH_SPACE);
					add_text("x");
					repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(33, 126)));
				end
				if ($urandom_range(1))
					add_byte(CH_CR);
			end
			add_byte(CH_LF);
		end
		// header lines
		repeat (($urandom_range(99) < 10) ? $urandom_range(4, 9) : $urandom_range(0, 3)) begin
			add_byte(8'($urandom_range(65, 90)));
			repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(32, 126)));
			if ($urandom_range(1))
				add_byte(CH_CR);
			add_byte(CH_LF);
		end
		r = $urandom_range(99);
		if (r < 45) begin
			add_byte(CH_CR);
			add_byte(CH_LF);
		end else if (r < 80) begin
			add_byte(CH_LF);
		end
		// cut the request short with end of input now and then
		if ($urandom_range(99) < 12) begin
			cut = $urandom_range(first, pending_beats.size() - 1);
			while (pending_beats.size() > cut)
				void'(pending_beats.pop_back());
			add_eoi();
		end else if ($urandom_range(99) < 8) begin
			add_eoi();
		end
	endtask

	initial begin : stimulus
		flow_e      phase_flow[NUM_PHASES];
		logic [7:0] phase_limit[NUM_PHASES];
		phase_flow  = '{FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH,
		                FLOW_FREE, FLOW_BOTH};
		phase_limit = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd20, 8'd2};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset header limit
		add_eoi();                                        // empty input
		add_line("GET / H");                              // headers end on CR LF
		add_byte(CH_CR);
		add_byte(CH_LF);
		add_line("POST /a.b_c-D9 HTTP/1.0");              // headers end on bare LF
		add_line("Host: x");
		add_byte(CH_LF);
		add_line("  GET  /x   V1 extra tok");             // spaces, extra tokens
		add_byte(CH_LF);
		add_line("GET /");                                // missing version
		add_line("GETS / V");                             // bad verbs
		add_line("POS / V");
		add_line("get / V");
		add_line("GET a V");                              // bad paths
		add_line("GET /a%b V");
		add_text("GET /");                                // path cut at the limit,
		repeat (29) add_text("a");                        // illegal byte past it
		add_line("! V");
		add_byte(CH_LF);
		add_line("GET / ");                               // version opens with LF
		add_line("POST / HTTP/1.1.1.1");                  // version cut at the limit
		add_byte(CH_LF);
		add_text("GET /a");                               // NUL ends the line early
		add_byte(CH_NUL);
		add_line("x y z");
		add_text("GET / V");
		add_byte(CH_NUL);
		add_line(" junk");
		add_byte(CH_LF);
		add_text("GET /");                                // top-bit byte in path
		add_byte(8'hFF);
		add_line(" V");
		add_byte(CH_LF);
		add_text("POST /q");                              // end inside the line
		add_eoi();
		add_line("GET / V");                              // end inside the headers
		add_line("Host");
		add_eoi();
		add_line("GET / V");                              // end after a CR opener
		add_byte(CH_CR);
		add_eoi();
		add_line("");                                     // lone LF
		add_eoi();
		// leave a request mid-headers, then lower the limit under it
		add_line("GET / V");
		add_line("A");
		add_line("B");
		send_all();

		// Random phases, each with its own limit and flow pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_set_limit(phase_limit[p]);
			flow <= phase_flow[p];
			if (p == PRESSURE_IDX)
				pressure_on <= 1'b1;
			beats_sent = 0;
			while (beats_sent < PHASE_BEATS) begin
				make_request();
				send_all();
			end
		end

		// Wait out every owed result, then give stray beats a chance to show
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hdl/hrlc_pkg.sv
hdl/hrlc_front.sv
hdl/hrlc_queue.sv
hdl/hrlc_back.sv
hdl/http_request_line_checker_top.sv
verif/hrlc_result_check.sv
verif/tb.sv
